// ===== design/gnu_pkg.sv =====
// Package for the packed G-code receiver: state and queue entry types,
// command and marker codes, nibble table and per-byte decode function.
// No dependencies; the front, queue, back and top modules import it.
package gnu_pkg;

  localparam logic [7:0] MARKER_BYTE  = 8'hFF;
  localparam logic [3:0] NIBBLE_FULL  = 4'hF;
  localparam logic [7:0] CMD_RESET    = 8'd249;
  localparam logic [7:0] CMD_DISABLE  = 8'd250;
  localparam logic [7:0] CMD_ENABLE   = 8'd251;
  localparam logic [7:0] CMD_TOGGLE   = 8'd253;

  localparam logic OP_LINK    = 1'b0;
  localparam logic OP_COMMAND = 1'b1;

  localparam int MAX_CHARS = 4;
  localparam int CNT_W     = $clog2(MAX_CHARS + 1);
  localparam int IDX_W     = $clog2(MAX_CHARS);

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic       unpack_on;
    logic       command_armed;
    logic       marker_seen;
    logic [1:0] owed;
    logic [7:0] held;
  } gnu_state_t;

  typedef struct packed {
    logic [MAX_CHARS-1:0][7:0] chars;
    logic [CNT_W-1:0]          count;
  } gnu_entry_t;

  typedef struct packed {
    gnu_state_t      st;
    logic [1:0][7:0] chars;
    logic [1:0]      n;
  } gnu_dec_t;

  function automatic logic [7:0] nibble_char(logic [3:0] code);
    logic [7:0] c;
    unique case (code)
      4'd0:    c = "0";
      4'd1:    c = "1";
      4'd2:    c = "2";
      4'd3:    c = "3";
      4'd4:    c = "4";
      4'd5:    c = "5";
      4'd6:    c = "6";
      4'd7:    c = "7";
      4'd8:    c = "8";
      4'd9:    c = "9";
      4'd10:   c = ".";
      4'd11:   c = " ";
      4'd12:   c = 8'h0A;
      4'd13:   c = "G";
      4'd14:   c = "X";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic gnu_state_t apply_command(gnu_state_t s, logic [7:0] code);
    gnu_state_t r;
    r = s;
    unique case (code)
      CMD_ENABLE:  r.unpack_on = 1'b1;
      CMD_DISABLE: r.unpack_on = 1'b0;
      CMD_TOGGLE:  r.unpack_on = ~s.unpack_on;
      CMD_RESET:   r = '0;
      default:     r = s;
    endcase
    return r;
  endfunction

  // Decode one byte: pass through, finish an owed full character, or
  // split into two nibble codes.
  function automatic gnu_dec_t decode_byte(gnu_state_t s, logic [7:0] b);
    gnu_dec_t   d;
    logic [3:0] lo;
    logic [3:0] hi;
    d.st    = s;
    d.chars = '0;
    d.n     = 2'd0;
    lo      = b[3:0];
    hi      = b[7:4];
    if (!s.unpack_on) begin
      d.chars[0] = b;
      d.n        = 2'd1;
    end else if (s.owed != 2'd0) begin
      d.chars[0] = b;
      d.n        = 2'd1;
      if (s.held != 8'd0) begin
        d.chars[1] = s.held;
        d.n        = 2'd2;
        d.st.held  = 8'd0;
      end
      d.st.owed = s.owed - 2'd1;
    end else if (lo == NIBBLE_FULL) begin
      if (hi == NIBBLE_FULL) begin
        d.st.owed = 2'd2;
      end else begin
        d.st.owed = 2'd1;
        d.st.held = nibble_char(hi);
      end
    end else begin
      d.chars[0] = nibble_char(lo);
      d.n        = 2'd1;
      if (hi == NIBBLE_FULL) begin
        d.st.owed = 2'd1;
      end else begin
        d.chars[1] = nibble_char(hi);
        d.n        = 2'd2;
      end
    end
    return d;
  endfunction

endpackage

// ===== design/gnu_in_if.sv =====
// Input channel of the packed G-code receiver: valid/ready plus one byte item.
// Depends on nothing.
interface gnu_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] byte_in;

  modport source (output valid, output operation, output byte_in, input ready);
  modport sink   (input valid, input operation, input byte_in, output ready);
endinterface

// ===== design/gnu_out_if.sv =====
// Output channel of the packed G-code receiver: valid/ready plus one character item.
// Depends on nothing.
interface gnu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_out;
  logic       last;

  modport source (output valid, output char_out, output last, input ready);
  modport sink   (input valid, input char_out, input last, output ready);
endinterface

// ===== design/gnu_front.sv =====
// Front end: accepts input items, tracks marker/command/unpack state and
// builds one queue entry of up to four characters per item. Uses gnu_pkg, gnu_in_if.
module gnu_front (
  input  logic               clk,
  input  logic               rst,
  gnu_in_if.sink             in_ch,
  input  logic               q_full,
  output logic               q_push,
  output gnu_pkg::gnu_entry_t q_entry
);
  import gnu_pkg::*;

  gnu_state_t st;
  gnu_state_t st_next;
  gnu_state_t mid;
  gnu_dec_t   d1;
  gnu_dec_t   d2;
  logic       accept;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    st_next       = st;
    q_entry.chars = '0;
    q_entry.count = '0;
    mid           = st;
    mid.marker_seen = 1'b0;
    d1            = decode_byte(mid, MARKER_BYTE);
    d2            = decode_byte(st.marker_seen ? d1.st : st, in_ch.byte_in);
    if (in_ch.operation == OP_COMMAND) begin
      st_next = apply_command(st, in_ch.byte_in);
    end else if (in_ch.byte_in == MARKER_BYTE) begin
      if (st.marker_seen) begin
        st_next.command_armed = 1'b1;
        st_next.marker_seen   = 1'b0;
      end else begin
        st_next.marker_seen = 1'b1;
      end
    end else if (st.command_armed) begin
      st_next               = apply_command(st, in_ch.byte_in);
      st_next.command_armed = 1'b0;
    end else if (st.marker_seen) begin
      // lone marker: decode it as data first, then the byte itself
      st_next = d2.st;
      unique case (d1.n)
        2'd0: begin
          q_entry.chars[1:0] = d2.chars;
        end
        2'd1: begin
          q_entry.chars[0]   = d1.chars[0];
          q_entry.chars[2:1] = d2.chars;
        end
        default: begin
          q_entry.chars[1:0] = d1.chars;
          q_entry.chars[3:2] = d2.chars;
        end
      endcase
      q_entry.count = CNT_W'(d1.n) + CNT_W'(d2.n);
    end else begin
      st_next            = d2.st;
      q_entry.chars[1:0] = d2.chars;
      q_entry.count      = CNT_W'(d2.n);
    end
  end

  assign q_push = accept && (q_entry.count != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (accept) begin
      st <= st_next;
    end
  end

endmodule

// ===== design/gnu_queue.sv =====
// Short queue of decoded character groups between front and back end.
// Uses gnu_pkg.
module gnu_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  gnu_pkg::gnu_entry_t wr_entry,
  input  logic                pop,
  output logic                full,
  output logic                not_empty,
  output gnu_pkg::gnu_entry_t rd_entry
);
  import gnu_pkg::*;

  gnu_entry_t          slots [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   fill;
  logic                do_push;
  logic                do_pop;

  assign full      = (fill == QCNT_W'(QDEPTH));
  assign not_empty = (fill != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign rd_entry  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      unique case ({do_push, do_pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ===== design/gnu_back.sv =====
// Back end: takes one character group from the queue, sends its characters
// one per ready cycle, marking the final one. Uses gnu_pkg, gnu_out_if.
module gnu_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  gnu_pkg::gnu_entry_t q_entry,
  output logic                q_pop,
  gnu_out_if.source           out_ch
);
  import gnu_pkg::*;

  logic             busy;
  gnu_entry_t       cur;
  logic [IDX_W-1:0] idx;
  logic             is_last;
  logic             advance;
  logic             load;

  assign is_last = ({1'b0, idx} == (cur.count - CNT_W'(1)));
  assign advance = busy && out_ch.ready;
  assign load    = !busy || (advance && is_last);
  assign q_pop   = load && q_valid;

  assign out_ch.valid    = busy;
  assign out_ch.char_out = cur.chars[idx];
  assign out_ch.last     = is_last;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (load) begin
      busy <= q_valid;
      idx  <= '0;
    end else if (advance) begin
      idx <= idx + 1'b1;
    end
  end

endmodule

// ===== design/gcode_nibble_unpacker_top.sv =====
// Top level of the packed G-code receiver.
// Depends on gnu_pkg, gnu_in_if, gnu_out_if, gnu_front, gnu_queue, gnu_back.
//
// Usage:
//   in_ch  (sink):   one item per received byte: operation (0 = link byte,
//                    1 = direct command code) and byte_in.
//   out_ch (source): decoded characters, one per item, char_out plus last,
//                    which marks the final character caused by one input.
//   An input causes zero to four characters. Two 0xFF bytes arm a command;
//   the next byte enables (251), disables (250), toggles (253) unpacking or
//   clears all state (249). Command bytes emit nothing.
// Path: an accepted input's group is written into the queue, then loaded
//   into the send register, which offers its first character.
// Throughput: input is taken every cycle while the four-group queue has
//   room; output sends one character per cycle while out_ch.ready is high,
//   and an input produces up to four characters.
// Reset: synchronous, clears unpack mode, marker/command tracking, owed
//   full characters, the held character, the queue pointers and send state.
// Stall: when out_ch.ready is low the current character holds; the queue
//   fills and in_ch.ready drops once four groups are waiting.
module gcode_nibble_unpacker_top (
  input logic       clk,
  input logic       rst,
  gnu_in_if.sink    in_ch,
  gnu_out_if.source out_ch
);
  import gnu_pkg::*;

  logic       q_full;
  logic       q_push;
  logic       q_pop;
  logic       q_not_empty;
  gnu_entry_t push_entry;
  gnu_entry_t head_entry;

  // Front: classify the byte, update state, build a character group.
  gnu_front u_front (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_entry (push_entry)
  );

  // Queue: decouple decode from the character-by-character send.
  gnu_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .wr_entry  (push_entry),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .rd_entry  (head_entry)
  );

  // Back: drain each group one character per cycle while out_ch.ready is high.
  gnu_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_not_empty),
    .q_entry (head_entry),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

// ===== design/gnu_checker.sv =====
// Port-level checker for the packed G-code receiver, bound to the top level.
// Depends on gcode_nibble_unpacker_top ports only.
module gnu_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] char_out,
  input logic       last
);

  // After reset nothing is pending and input is open.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> (!out_valid && in_ready))
    else $error("output pending or input blocked after reset");

  // Hold a stalled character.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(char_out) && $stable(last)))
    else $error("stalled character changed");

  // A group is sent without gaps until its last character.
  a_group_cont: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !last) |=> out_valid)
    else $error("gap inside a character group");

endmodule

bind gcode_nibble_unpacker_top gnu_checker u_gnu_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .char_out  (out_ch.char_out),
  .last      (out_ch.last)
);

// ===== verif/tb.sv =====
// Self-checking testbench for gcode_nibble_unpacker_top: drives byte items,
// predicts the decoded characters and checks every character item that comes out.
// Depends on gnu_pkg, gnu_in_if, gnu_out_if and the design under design/.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gnu_pkg::*;

  // Pacing of the stimulus: who idles and how often.
  typedef enum logic [1:0] {
    PH_RECV_SLOW,   // sender idle chance 31 percent, receiver 54
    PH_SEND_SLOW,   // sender idles 54, receiver 31
    PH_FULL_RATE    // neither side idles
  } pace_t;

  // One byte item waiting to be offered on the input channel.
  typedef struct {
    logic       op;
    logic [7:0] data;
    pace_t      pace;
    logic       drain_first;  // hold back until every expected character has come
    logic       hold_after;   // start a long receiver stall when this item goes out
  } byte_item_t;

  // One expected character item.
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } char_item_t;

  // Query code of the protocol; it must leave the decoder untouched.
  localparam logic [7:0] CMD_QUERY = 8'd248;

  localparam int HOLD_CYCLES  = 80;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 200000;

  logic clk;
  logic rst;

  gnu_in_if  in_ch ();
  gnu_out_if out_ch ();

  gcode_nibble_unpacker_top u_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Decoder prediction. The state mirrors the receiver: unpack mode, the
  // marker/command tracking, how many full characters are still owed and the
  // packed character parked behind them.
  // ---------------------------------------------------------------------------
  logic       unpack_en;
  logic       cmd_armed;
  logic       ff_pending;
  logic [1:0] full_owed;
  logic [7:0] parked_char;

  logic [7:0] burst[$];        // characters caused by the byte being predicted
  char_item_t exp_chars[$];    // characters still to come out, oldest first

  function automatic void clear_decoder();
    unpack_en   = 1'b0;
    cmd_armed   = 1'b0;
    ff_pending  = 1'b0;
    full_owed   = 2'd0;
    parked_char = 8'd0;
  endfunction

  // Map one 4-bit code to its character; the escape code has no character.
  function automatic logic [7:0] table_char(logic [3:0] code);
    logic [7:0] c;
    case (code)
      4'hA:    c = ".";
      4'hB:    c = " ";
      4'hC:    c = 8'h0A;
      4'hD:    c = "G";
      4'hE:    c = "X";
      4'hF:    c = 8'h00;
      default: c = 8'h30 + {4'h0, code};
    endcase
    return c;
  endfunction

  function automatic void add_char(logic [7:0] c);
    if (burst.size() < MAX_CHARS)
      burst.push_back(c);
  endfunction

  function automatic void run_command(logic [7:0] code);
    case (code)
      CMD_ENABLE:  unpack_en = 1'b1;
      CMD_DISABLE: unpack_en = 1'b0;
      CMD_TOGGLE:  unpack_en = ~unpack_en;
      CMD_RESET:   clear_decoder();
      default: ;   // query and unknown codes do nothing
    endcase
  endfunction

  function automatic void unpack_byte(logic [7:0] b);
    logic [3:0] lo;
    logic [3:0] hi;
    lo = b[3:0];
    hi = b[7:4];
    if (!unpack_en) begin
      add_char(b);
    end else if (full_owed != 2'd0) begin
      // A full character; release the parked packed one right behind it.
      add_char(b);
      if (parked_char != 8'd0) begin
        add_char(parked_char);
        parked_char = 8'd0;
      end
      full_owed = full_owed - 2'd1;
    end else if (lo == NIBBLE_FULL) begin
      if (hi == NIBBLE_FULL) begin
        full_owed = 2'd2;
      end else begin
        full_owed   = 2'd1;
        parked_char = table_char(hi);
      end
    end else begin
      add_char(table_char(lo));
      if (hi == NIBBLE_FULL)
        full_owed = 2'd1;
      else
        add_char(table_char(hi));
    end
  endfunction

  // Advance the prediction by one accepted byte item and queue its characters.
  function automatic void predict_byte(logic op, logic [7:0] b);
    char_item_t e;
    burst.delete();
    if (op == OP_COMMAND) begin
      run_command(b);
    end else if (b == MARKER_BYTE) begin
      if (ff_pending) begin
        cmd_armed  = 1'b1;
        ff_pending = 1'b0;
      end else begin
        ff_pending = 1'b1;
      end
    end else if (cmd_armed) begin
      run_command(b);
      cmd_armed = 1'b0;
    end else begin
      // A lone marker is an ordinary byte after all: decode it first.
      if (ff_pending) begin
        unpack_byte(MARKER_BYTE);
        ff_pending = 1'b0;
      end
      unpack_byte(b);
    end
    foreach (burst[k]) begin
      e.ch   = burst[k];
      e.last = (k == burst.size() - 1);
      exp_chars.push_back(e);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Pacing helpers.
  // ---------------------------------------------------------------------------
  function automatic int sender_idle_pct(pace_t p);
    case (p)
      PH_RECV_SLOW: return 31;
      PH_SEND_SLOW: return 54;
      default:      return 0;
    endcase
  endfunction

  function automatic int receiver_idle_pct(pace_t p);
    case (p)
      PH_RECV_SLOW: return 54;
      PH_SEND_SLOW: return 31;
      default:      return 0;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus plan: the initial block fills byte_plan, the driver empties it.
  // ---------------------------------------------------------------------------
  byte_item_t byte_plan[$];
  int         planned;
  pace_t      plan_pace;
  logic       plan_drain;
  logic       plan_hold;

  // Append one byte item; the drain and hold flags apply to this item only.
  function automatic void plan_byte(logic op, logic [7:0] data);
    byte_item_t it;
    it.op          = op;
    it.data        = data;
    it.pace        = plan_pace;
    it.drain_first = plan_drain;
    it.hold_after  = plan_hold;
    byte_plan.push_back(it);
    planned++;
    plan_drain = 1'b0;
    plan_hold  = 1'b0;
  endfunction

  // Command code for random sequences: enable and random codes most often.
  function automatic logic [7:0] pick_code();
    case ($urandom_range(9))
      0, 1, 2: return CMD_ENABLE;
      3:       return CMD_TOGGLE;
      4:       return CMD_DISABLE;
      5:       return CMD_RESET;
      6:       return CMD_QUERY;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Random part of one pacing phase: mostly well-formed packed traffic with
  // armed commands, lone markers, escapes and some raw noise mixed in.
  task automatic plan_random(pace_t pace, int n, logic drain, logic hold);
    int goal;
    int r;
    int extra;
    goal       = planned + n;
    plan_pace  = pace;
    plan_drain = drain;
    // Open each phase by switching unpacking on through an armed pair.
    plan_byte(OP_LINK, MARKER_BYTE);
    plan_byte(OP_LINK, MARKER_BYTE);
    plan_byte(OP_LINK, CMD_ENABLE);
    plan_hold = hold;
    while (planned < goal) begin
      r = $urandom_range(99);
      if (r < 55) begin
        plan_byte(OP_LINK, 8'($urandom_range(254)));
      end else if (r < 65) begin
        plan_byte(OP_LINK, MARKER_BYTE);
        plan_byte(OP_LINK, MARKER_BYTE);
        plan_byte(OP_LINK, pick_code());
      end else if (r < 73) begin
        plan_byte(OP_LINK, MARKER_BYTE);
        plan_byte(OP_LINK, 8'($urandom_range(254)));
      end else if (r < 81) begin
        plan_byte(OP_COMMAND, pick_code());
      end else if (r < 91) begin
        // Escape nibble in either half, then one or two further bytes.
        if ($urandom_range(1))
          plan_byte(OP_LINK, {4'($urandom_range(15)), NIBBLE_FULL});
        else
          plan_byte(OP_LINK, {NIBBLE_FULL, 4'($urandom_range(14))});
        extra = $urandom_range(1, 2);
        repeat (extra) plan_byte(OP_LINK, 8'($urandom_range(254)));
      end else begin
        plan_byte(1'($urandom_range(1)), 8'($urandom_range(255)));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Byte driver: offer the next planned item, hold it until accepted.
  // ---------------------------------------------------------------------------
  byte_item_t cur_byte;
  logic       byte_busy;
  pace_t      src_pace;
  logic       hold_req;

  always @(posedge clk) begin : byte_driver
    logic take_next;
    take_next = 1'b0;
    if (rst) begin
      in_ch.valid     <= 1'b0;
      in_ch.operation <= OP_LINK;
      in_ch.byte_in   <= 8'd0;
      hold_req        <= 1'b0;
      src_pace        <= PH_RECV_SLOW;
      byte_busy = 1'b0;
    end else begin
      // Predict on the edge that accepts the item.
      if (in_ch.valid && in_ch.ready) begin
        predict_byte(cur_byte.op, cur_byte.data);
        byte_busy = 1'b0;
      end
      if (!byte_busy && byte_plan.size() != 0) begin
        if (byte_plan[0].drain_first)
          take_next = (exp_chars.size() == 0);
        else
          take_next = ($urandom_range(99) >= sender_idle_pct(byte_plan[0].pace));
      end
      if (take_next) begin
        cur_byte = byte_plan.pop_front();
        byte_busy = 1'b1;
        in_ch.operation <= cur_byte.op;
        in_ch.byte_in   <= cur_byte.data;
        src_pace        <= cur_byte.pace;
      end
      in_ch.valid <= byte_busy;
      hold_req    <= take_next && cur_byte.hold_after;
    end
  end

  // ---------------------------------------------------------------------------
  // Character monitor: pace the receiver and check each accepted character
  // against the oldest expectation. A hold request stalls the receiver for a
  // long stretch so the block fills up and drops its input ready.
  // ---------------------------------------------------------------------------
  int n_errors;
  int hold_left;

  always @(posedge clk) begin : char_monitor
    char_item_t want;
    if (rst) begin
      out_ch.ready <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (exp_chars.size() == 0) begin
          $error("unexpected character item: char_out %h last %b",
                 out_ch.char_out, out_ch.last);
          n_errors++;
        end else begin
          want = exp_chars.pop_front();
          if (out_ch.char_out !== want.ch) begin
            $error("char_out mismatch: expected %h, actual %h", want.ch, out_ch.char_out);
            n_errors++;
          end
          if (out_ch.last !== want.last) begin
            $error("last mismatch: expected %b, actual %b", want.last, out_ch.last);
            n_errors++;
          end
        end
      end
      if (hold_req)
        hold_left = HOLD_CYCLES;
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= receiver_idle_pct(src_pace));
      end
    end
  end

  // Cycle limit: a hung handshake ends the run here.
  int cycle_count;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence: build the plan, release reset, wait for the drain.
  // ---------------------------------------------------------------------------
  initial begin
    clk              = 1'b0;
    rst              = 1'b1;
    in_ch.valid      = 1'b0;
    in_ch.operation  = OP_LINK;
    in_ch.byte_in    = 8'd0;
    out_ch.ready     = 1'b0;
    n_errors         = 0;
    cycle_count      = 0;
    planned          = 0;
    plan_drain       = 1'b0;
    plan_hold        = 1'b0;
    plan_pace        = PH_RECV_SLOW;
    clear_decoder();

    // Directed part. Unpacking starts off: bytes pass straight through.
    plan_byte(OP_LINK, 8'h41);
    // Lone marker before a normal byte: the marker comes out first.
    plan_byte(OP_LINK, MARKER_BYTE);
    plan_byte(OP_LINK, 8'h42);
    // Armed pair turns unpacking on; the code byte emits nothing.
    plan_byte(OP_LINK, MARKER_BYTE);
    plan_byte(OP_LINK, MARKER_BYTE);
    plan_byte(OP_LINK, CMD_ENABLE);
    // Plain packed pairs, low nibble first, across the table.
    plan_byte(OP_LINK, 8'h10);
    plan_byte(OP_LINK, 8'hDE);
    plan_byte(OP_LINK, 8'hCB);
    // Escape in the high nibble: one packed char, then one full char.
    plan_byte(OP_LINK, 8'hF3);
    plan_byte(OP_LINK, 8'h7A);
    // Escape in the low nibble parks the high char; a lone marker then
    // releases it and the next byte adds two more: four characters at once.
    plan_byte(OP_LINK, 8'h9F);
    plan_byte(OP_LINK, MARKER_BYTE);
    plan_byte(OP_LINK, 8'h45);
    // Lone marker decoded as a packed byte: both nibbles escape, two owed.
    plan_byte(OP_LINK, MARKER_BYTE);
    plan_byte(OP_LINK, 8'h31);
    plan_byte(OP_LINK, 8'h32);
    // Direct query and unknown codes change nothing.
    plan_byte(OP_COMMAND, CMD_QUERY);
    plan_byte(OP_COMMAND, 8'h00);
    // Owed character survives a disable: bytes pass, then it is finished.
    plan_byte(OP_LINK, 8'hAF);
    plan_byte(OP_COMMAND, CMD_DISABLE);
    plan_byte(OP_LINK, 8'h33);
    plan_byte(OP_COMMAND, CMD_TOGGLE);
    plan_byte(OP_LINK, 8'h44);
    // Marker while armed: the code applies and the marker stays pending.
    plan_byte(OP_LINK, MARKER_BYTE);
    plan_byte(OP_LINK, MARKER_BYTE);
    plan_byte(OP_LINK, MARKER_BYTE);
    plan_byte(OP_LINK, CMD_TOGGLE);
    plan_byte(OP_LINK, 8'h12);
    // Direct reset clears everything, then a raw byte passes.
    plan_byte(OP_COMMAND, CMD_RESET);
    plan_byte(OP_LINK, 8'hFE);

    // Random part in three pacing phases: the first opens with a long
    // receiver stall, the second waits for a full drain before it starts.
    plan_random(PH_RECV_SLOW, 134, 1'b0, 1'b1);
    plan_random(PH_SEND_SLOW, 134, 1'b1, 1'b0);
    plan_random(PH_FULL_RATE, 134, 1'b0, 1'b0);

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Wait for every item to go in and every character to come out, then
    // keep the clock running so that any extra character shows.
    while (byte_plan.size() != 0 || byte_busy) @(posedge clk);
    while (exp_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (n_errors == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== sim.f =====
design/gnu_pkg.sv
design/gnu_in_if.sv
design/gnu_out_if.sv
design/gnu_front.sv
design/gnu_queue.sv
design/gnu_back.sv
design/gcode_nibble_unpacker_top.sv
design/gnu_checker.sv
verif/tb.sv
